// File: rtl/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg
// Types and codes for the multi-queue shared buffer unit.
// ----------------------------------------------------------------------------
package mqsb_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_QUEUES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE   = 2'd1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam logic [3:0] ACTIVE_RESET = 4'd8;
	localparam logic [5:0] REGION_RESET = 6'd32;

	typedef struct packed {
		logic               func;
		logic [2:0]         queue_id;
		logic signed [31:0] data_in;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data_out;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_ENQ,
		OP_DEQ,
		OP_INVALID
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  queue_id;
		logic [31:0] data;
	} cmd_t;

	typedef struct packed {
		logic       clear;
		logic [5:0] region_size;
	} ctl_t;

endpackage

// File: rtl/mqsb_front.sv
// ----------------------------------------------------------------------------
// mqsb_front
// Config registers and request classification ahead of the command queue.
// ----------------------------------------------------------------------------
module mqsb_front #(
	parameter int NUM_QUEUES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  mqsb_pkg::req_t                  req,
	input  logic                            cfg_we,
	input  logic [mqsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mqsb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            fifo_full,
	output logic                            busy,
	output logic                            push,
	output mqsb_pkg::cmd_t                  cmd,
	output mqsb_pkg::ctl_t                  ctl
);
	import mqsb_pkg::*;

	logic [3:0] active_q;
	logic [5:0] region_q;
	logic       invalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			region_q <= REGION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_QUEUES: active_q <= cfg_data[3:0];
				REG_REGION_SIZE:   region_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		invalid = ({1'b0, req.queue_id} >= active_q) ||
			({4'd0, req.queue_id} >= 7'(NUM_QUEUES));
		cmd.op       = invalid ? OP_INVALID : (req.func ? OP_DEQ : OP_ENQ);
		cmd.queue_id = req.queue_id;
		cmd.data     = req.data_in;
	end

	assign busy = fifo_full;
	assign push = start && !fifo_full;

	assign ctl.clear = cfg_we &&
		(cfg_index == REG_ACTIVE_QUEUES || cfg_index == REG_REGION_SIZE);
	assign ctl.region_size = region_q;

endmodule

// File: rtl/mqsb_fifo.sv
// ----------------------------------------------------------------------------
// mqsb_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module mqsb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mqsb_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output mqsb_pkg::cmd_t head
);
	import mqsb_pkg::*;

	cmd_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = ent_q[rptr_q];

endmodule

// File: rtl/mqsb_back.sv
// ----------------------------------------------------------------------------
// mqsb_back
// Per-queue counts, shared slot memory and result register.
// ----------------------------------------------------------------------------
module mqsb_back #(
	parameter int NUM_QUEUES = 8,
	parameter int REGION_MAX = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fifo_empty,
	input  mqsb_pkg::cmd_t head,
	input  mqsb_pkg::ctl_t ctl,
	output logic           pop,
	output logic           done,
	output mqsb_pkg::rsp_t rsp
);
	import mqsb_pkg::*;

	localparam int Q_EFF     = (NUM_QUEUES < 8) ? NUM_QUEUES : 8;
	localparam int QW        = (Q_EFF > 1) ? $clog2(Q_EFF) : 1;
	localparam int LIM       = (REGION_MAX < 63) ? REGION_MAX : 63;
	localparam int CNT_W     = $clog2(LIM + 1);
	localparam int MEM_DEPTH = Q_EFF * REGION_MAX;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int SW        = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

	logic [CNT_W-1:0] wcnt_q [Q_EFF];
	logic [CNT_W-1:0] rcnt_q [Q_EFF];
	logic [SW-1:0]    mem [MEM_DEPTH];

	logic [QW-1:0]    qi;
	logic [CNT_W-1:0] wc;
	logic [CNT_W-1:0] rc;
	logic [CNT_W-1:0] lim;
	logic             is_full;
	logic             is_empty;
	logic             enq_ok;
	logic             deq_ok;
	logic [1:0]       status;
	logic [AW-1:0]    addr;

	logic             done_q;
	logic [1:0]       status_q;
	logic             deq_ok_q;
	logic [SW-1:0]    rd_q;
	logic signed [SW-1:0] rd_s;

	assign pop = !fifo_empty;

	always_comb begin
		qi       = head.queue_id[QW-1:0];
		wc       = wcnt_q[qi];
		rc       = rcnt_q[qi];
		lim      = (ctl.region_size > 6'(LIM)) ? CNT_W'(LIM) : CNT_W'(ctl.region_size);
		is_full  = wc >= lim;
		is_empty = rc >= wc;
		case (head.op)
			OP_ENQ:     status = is_full ? ST_FULL : ST_OK;
			OP_DEQ:     status = is_empty ? ST_EMPTY : ST_OK;
			OP_INVALID: status = ST_INVALID;
			default:    status = ST_INVALID;
		endcase
		enq_ok = pop && head.op == OP_ENQ && !is_full;
		deq_ok = pop && head.op == OP_DEQ && !is_empty;
		addr   = AW'(qi) * AW'(REGION_MAX) + AW'(enq_ok ? wc : rc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Q_EFF; i++) begin
				wcnt_q[i] <= '0;
				rcnt_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			for (int i = 0; i < Q_EFF; i++) begin
				wcnt_q[i] <= '0;
				rcnt_q[i] <= '0;
			end
		end else begin
			if (enq_ok) begin
				wcnt_q[qi] <= wc + CNT_W'(1);
			end
			if (deq_ok) begin
				rcnt_q[qi] <= rc + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq_ok) begin
			mem[addr] <= head.data[SW-1:0];
		end
		if (deq_ok) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= ST_OK;
			deq_ok_q <= 1'b0;
		end else begin
			done_q   <= pop;
			status_q <= status;
			deq_ok_q <= deq_ok;
		end
	end

	assign rd_s         = rd_q;
	assign done         = done_q;
	assign rsp.status   = status_q;
	assign rsp.data_out = deq_ok_q ? 32'(rd_s) : 32'sd0;

endmodule

// File: rtl/multi_queue_shared_buffer_unit.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_unit
// Several linear queues sharing one slot memory, one fixed region each.
// ----------------------------------------------------------------------------
//  channel   ports                            handshake
//  request   start, busy, req                 taken when start && !busy
//  result    done, rsp                        one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_data      written when cfg_we
//
//  One word accepted per cycle while busy is low; it passes the queue entry,
//  then count lookup and slot memory access into the result register.
//  Reset: 8 active queues, region size 32, all counts zero; slot memory is
//  not cleared. A write to either defined config register clears every count.
//  The back end drains one command per cycle, so busy stays low in use.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_unit #(
	parameter int NUM_QUEUES = 8,
	parameter int REGION_MAX = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  mqsb_pkg::req_t                  req,
	output logic                            done,
	output mqsb_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [mqsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mqsb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mqsb_pkg::*;

	logic fifo_full;
	logic fifo_empty;
	logic push;
	logic pop;
	cmd_t cmd;
	cmd_t head;
	ctl_t ctl;

	mqsb_front #(
		.NUM_QUEUES(NUM_QUEUES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.fifo_full(fifo_full),
		.busy     (busy),
		.push     (push),
		.cmd      (cmd),
		.ctl      (ctl)
	);

	mqsb_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(cmd),
		.pop     (pop),
		.full    (fifo_full),
		.empty   (fifo_empty),
		.head    (head)
	);

	mqsb_back #(
		.NUM_QUEUES(NUM_QUEUES),
		.REGION_MAX(REGION_MAX),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_empty(fifo_empty),
		.head      (head),
		.ctl       (ctl),
		.pop       (pop),
		.done      (done),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> done)
		else $error("popped command gave no result");

	a_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		!fifo_full)
		else $error("command queue filled up");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> rsp.data_out == 32'sd0)
		else $error("nonzero data on failed request");

	a_invalid_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd.op == OP_INVALID) |-> ##2 (done && rsp.status == ST_INVALID))
		else $error("rejected request not reported");
`endif

endmodule

// File: test/mqsb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mqsb_checker
// Watches the request, result and register channels of the multi-queue shared
// buffer unit. It keeps its own copy of the counts, slots and register values,
// works out the result of every word taken, and compares each result strobe
// with the oldest one still due.
// ----------------------------------------------------------------------------
module mqsb_checker #(
	parameter int NUM_QUEUES = 8,
	parameter int REGION_MAX = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  mqsb_pkg::req_t                  req,
	input  logic                            done,
	input  mqsb_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [mqsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mqsb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);
	import mqsb_pkg::*;

	logic [3:0]  active_cfg;
	logic [5:0]  region_cfg;
	logic [5:0]  wr_cnt [NUM_QUEUES];
	logic [5:0]  rd_cnt [NUM_QUEUES];
	logic [31:0] slot_mem [NUM_QUEUES * REGION_MAX];
	rsp_t        due_rsps [$];
	int          errs;

	function automatic void clear_counts();
		for (int i = 0; i < NUM_QUEUES; i++) begin
			wr_cnt[i] = '0;
			rd_cnt[i] = '0;
		end
	endfunction

	function automatic rsp_t apply_request(req_t w);
		rsp_t r;
		int   lim_q;
		int   lim_r;
		int   q;
		r = '0;
		r.status = ST_OK;
		lim_q = (active_cfg > NUM_QUEUES) ? NUM_QUEUES : active_cfg;
		lim_r = (region_cfg > REGION_MAX) ? REGION_MAX : region_cfg;
		q = w.queue_id;
		if (q >= lim_q || q >= NUM_QUEUES) begin
			r.status = ST_INVALID;
		end else if (w.func == 1'(OP_ENQ)) begin
			if (wr_cnt[q] >= lim_r) begin
				r.status = ST_FULL;
			end else begin
				slot_mem[q * REGION_MAX + wr_cnt[q]] = w.data_in;
				wr_cnt[q] = wr_cnt[q] + 6'd1;
			end
		end else begin
			if (rd_cnt[q] >= wr_cnt[q] || rd_cnt[q] >= REGION_MAX) begin
				r.status = ST_EMPTY;
			end else begin
				r.data_out = slot_mem[q * REGION_MAX + rd_cnt[q]];
				rd_cnt[q] = rd_cnt[q] + 6'd1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			active_cfg = ACTIVE_RESET;
			region_cfg = REGION_RESET;
			clear_counts();
			due_rsps.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (due_rsps.size() == 0) begin
					$display("%0t: unexpected result word status %0d data %h", $time,
						rsp.status, rsp.data_out);
					errs++;
				end else begin
					exp_rsp = due_rsps.pop_front();
					if (rsp.status !== exp_rsp.status) begin
						$display("%0t: status expected %0d, got %0d", $time,
							exp_rsp.status, rsp.status);
						errs++;
					end
					if (rsp.data_out !== exp_rsp.data_out) begin
						$display("%0t: data_out expected %h, got %h", $time,
							exp_rsp.data_out, rsp.data_out);
						errs++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_ACTIVE_QUEUES) begin
					active_cfg = cfg_data[3:0];
					clear_counts();
				end else if (cfg_index == REG_REGION_SIZE) begin
					region_cfg = cfg_data[5:0];
					clear_counts();
				end
			end
			if (start && !busy)
				due_rsps.push_back(apply_request(req));
			fail_count <= errs;
			pending <= due_rsps.size();
		end
	end

endmodule

// File: test/tb_multi_queue_shared_buffer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_queue_shared_buffer_unit
// Drives the multi-queue shared buffer unit with a short directed sequence
// (field extremes, full, empty, rejected queue numbers, clipped and zero
// register values, spare register indexes) and then with phases of random
// fill and drain traffic under changing register settings. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_multi_queue_shared_buffer_unit;
	import mqsb_pkg::*;

	localparam int NUM_QUEUES = 8;
	localparam int REGION_MAX = 32;
	localparam int QUIET_LIMIT = 1000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	req_t                  req = '0;
	logic                  done;
	rsp_t                  rsp;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count;
	int                    pending;
	int                    quiet = 0;
	int                    items_sent = 0;
	int                    stim_active = NUM_QUEUES;
	bit                    gaps_on = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	multi_queue_shared_buffer_unit #(
		.NUM_QUEUES(NUM_QUEUES),
		.REGION_MAX(REGION_MAX),
		.DATA_WIDTH(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mqsb_checker #(
		.NUM_QUEUES(NUM_QUEUES),
		.REGION_MAX(REGION_MAX)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_word(input op_t op, input logic [2:0] qid, input logic [31:0] val);
		req_t w;
		w.func = 1'(op);
		w.queue_id = qid;
		w.data_in = val;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// registers only change with the unit drained
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ACTIVE_QUEUES)
			stim_active = (val[3:0] > NUM_QUEUES) ? NUM_QUEUES : val[3:0];
	endtask

	initial begin
		int          fixed_a [8];
		int          fixed_r [8];
		int          phase;
		int          len;
		int          enq_pct;
		logic [5:0]  a_val;
		logic [5:0]  r_val;
		logic [2:0]  qid;
		logic [31:0] val;
		op_t         op;
		fixed_a = '{1, 2, 8, 15, 0, 4, 9, 8};
		fixed_r = '{32, 63, 5, 1, 7, 0, 12, 3};
		phase = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, empty, full, no slot reuse
		send_word(OP_DEQ, 3'd0, 32'h0);
		send_word(OP_ENQ, 3'd0, 32'h7FFF_FFFF);
		send_word(OP_ENQ, 3'd0, 32'h8000_0000);
		send_word(OP_ENQ, 3'd7, 32'hFFFF_FFFF);
		send_word(OP_ENQ, 3'd7, 32'h0);
		send_word(OP_DEQ, 3'd0, 32'hFFFF_FFFF);
		send_word(OP_DEQ, 3'd0, 32'h0);
		send_word(OP_DEQ, 3'd0, 32'h0);
		send_word(OP_DEQ, 3'd7, 32'h0);
		send_word(OP_DEQ, 3'd7, 32'h0);
		set_reg(REG_REGION_SIZE, 6'd1);
		send_word(OP_ENQ, 3'd3, 32'h1234_5678);
		send_word(OP_ENQ, 3'd3, 32'h9ABC_DEF0);
		send_word(OP_DEQ, 3'd3, 32'h0);
		send_word(OP_DEQ, 3'd3, 32'h0);
		set_reg(REG_REGION_SIZE, 6'd0);
		send_word(OP_ENQ, 3'd1, 32'h5555_5555);
		set_reg(REG_ACTIVE_QUEUES, 6'd0);
		send_word(OP_ENQ, 3'd0, 32'hAAAA_AAAA);
		send_word(OP_DEQ, 3'd0, 32'h0);
		set_reg(REG_REGION_SIZE, 6'd63);
		set_reg(REG_ACTIVE_QUEUES, 6'd3);
		send_word(OP_ENQ, 3'd3, 32'h0000_0001);
		send_word(OP_ENQ, 3'd2, 32'hC0DE_0002);
		set_reg(REG_ACTIVE_QUEUES, 6'd15);
		send_word(OP_ENQ, 3'd7, 32'h8000_0001);
		set_reg(REG_SPARE_LO, 6'd1);
		send_word(OP_DEQ, 3'd7, 32'h0);

		// random: fill then drain under each setting
		while (items_sent < 500) begin
			if (phase < 8) begin
				a_val = 6'(fixed_a[phase]);
				r_val = 6'(fixed_r[phase]);
				len = 80;
			end else begin
				a_val = 6'($urandom_range(0, 63));
				r_val = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(1, 8));
				len = $urandom_range(40, 80);
			end
			if ($urandom_range(0, 2) == 0)
				set_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					6'($urandom_range(0, 63)));
			if ($urandom_range(0, 1)) begin
				set_reg(REG_ACTIVE_QUEUES, a_val);
				set_reg(REG_REGION_SIZE, r_val);
			end else begin
				set_reg(REG_REGION_SIZE, r_val);
				set_reg(REG_ACTIVE_QUEUES, a_val);
			end
			gaps_on = (items_sent < 420) && ($urandom_range(0, 4) != 0);
			for (int i = 0; i < len; i++) begin
				enq_pct = (i < len / 2) ? 85 : 25;
				op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
				if (stim_active > 0 && $urandom_range(0, 9) != 0)
					qid = 3'($urandom_range(0, stim_active - 1));
				else
					qid = 3'($urandom_range(0, 7));
				case ($urandom_range(0, 7))
					0:       val = 32'h7FFF_FFFF;
					1:       val = 32'h8000_0000;
					default: val = $urandom;
				endcase
				send_word(op, qid, val);
			end
			phase++;
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
